@@ src/rtru_pkg.sv @@
package rtru_pkg;

  // Field widths
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned COST_W      = 16;
  localparam int unsigned COUNT_OUT_W = 6;
  localparam int unsigned STATUS_W    = 3;

  // Default table size
  localparam int unsigned TABLE_DEPTH_DEF = 32;

  // Saturation value for path costs
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // APB register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_OWN_ADDR = '0;

  // Request actions
  localparam logic ACT_NEIGHBOR = 1'b0;
  localparam logic ACT_ADVERT   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SELF      = 3'd0,
    STATUS_INSERTED  = 3'd1,
    STATUS_IMPROVED  = 3'd2,
    STATUS_UNCHANGED = 3'd3,
    STATUS_FULL      = 3'd4,
    STATUS_NOVIA     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VIA_SCAN,
    ST_DEST_SCAN,
    ST_RESULT
  } state_e;

  // One table entry as held in memory
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] via;
    logic [COST_W-1:0] cost;
  } entry_t;

  // Outcome of a table search
  typedef struct packed {
    logic done;
    logic found;
  } scan_res_t;

endpackage

@@ src/route_table_relax_update.sv @@
// Routing table relaxation engine. Requests are taken one at a time: a request
// for another node runs a linear search of the table memory for the via node
// (advertised requests via another node only) and then for the destination,
// one entry read per cycle through the single read port of the table memory.
// The result is presented in the same cycle in which the next request can be
// taken. The finished result sits in an output register, and the next request
// is accepted while it waits; a further result holds the sequencer until the
// waiting one is taken. The table needs no clearing after reset: only entries
// below the fill count are ever searched.
// own_address lies at APB byte address 0.
module route_table_relax_update #(
  parameter int unsigned TABLE_DEPTH = rtru_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rtru_pkg::APB_AW-1:0]          paddr,
  input  logic [rtru_pkg::APB_DW-1:0]          pwdata,
  output logic [rtru_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  // Request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic [rtru_pkg::ADDR_W-1:0]          dest_address_i,
  input  logic [rtru_pkg::ADDR_W-1:0]          via_address_i,
  input  logic [rtru_pkg::COST_W-1:0]          entry_cost_i,
  input  logic                                 last_in_advert_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rtru_pkg::STATUS_W-1:0]        status_o,
  output logic [rtru_pkg::COST_W-1:0]          path_cost_o,
  output logic [rtru_pkg::COUNT_OUT_W-1:0]     table_count_o,
  output logic                                 last_done_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(rtru_pkg::entry_t);

  rtru_pkg::state_e            state_q, state_d;
  logic [rtru_pkg::ADDR_W-1:0] own_q;
  logic [CW-1:0]               count_q, count_d;

  // Held request
  logic [rtru_pkg::ADDR_W-1:0] dest_q, dest_d;
  logic [rtru_pkg::ADDR_W-1:0] via_q, via_d;
  logic [rtru_pkg::COST_W-1:0] cost_q, cost_d;
  logic                        last_q, last_d;

  // Pending result
  rtru_pkg::status_e           res_status_q, res_status_d;
  logic [rtru_pkg::COST_W-1:0] res_cost_q, res_cost_d;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic [rtru_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [rtru_pkg::COST_W-1:0]    out_cost_q, out_cost_d;
  logic [rtru_pkg::COUNT_OUT_W-1:0] out_count_q, out_count_d;
  logic                           out_last_q, out_last_d;

  // Memory and search
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  rtru_pkg::entry_t            ram_wentry;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [EW-1:0]               ram_rdata;
  rtru_pkg::entry_t            rd_entry;
  logic                        scan_start;
  logic [rtru_pkg::ADDR_W-1:0] scan_key;
  rtru_pkg::scan_res_t         scan_res;
  logic [AW-1:0]               hit_idx;

  logic                        in_accept;
  logic                        out_load;
  logic [rtru_pkg::COST_W:0]   sum_wide;
  logic [rtru_pkg::COST_W-1:0] sum_sat;
  logic                        cfg_write;

  rtru_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rtru_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .key_i     (scan_key),
    .count_i   (count_q),
    .rd_en_o   (ram_re),
    .rd_addr_o (ram_raddr),
    .rd_dest_i (rd_entry.dest),
    .res_o     (scan_res),
    .hit_idx_o (hit_idx)
  );

  assign rd_entry = rtru_pkg::entry_t'(ram_rdata);

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[rtru_pkg::APB_AW-1:2] == rtru_pkg::REG_OWN_ADDR);
  assign prdata    = (paddr[rtru_pkg::APB_AW-1:2] == rtru_pkg::REG_OWN_ADDR)
                     ? rtru_pkg::APB_DW'(own_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
    end else if (cfg_write) begin
      own_q <= pwdata[rtru_pkg::ADDR_W-1:0];
    end
  end

  assign in_stall_o = (state_q != rtru_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Saturating add of the advertised cost and the via entry's cost
  assign sum_wide = {1'b0, cost_q} + {1'b0, rd_entry.cost};
  assign sum_sat  = sum_wide[rtru_pkg::COST_W] ? rtru_pkg::COST_MAX
                                               : sum_wide[rtru_pkg::COST_W-1:0];

  // Sequencer: via search, destination search, table update, result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dest_d       = dest_q;
    via_d        = via_q;
    cost_d       = cost_q;
    last_d       = last_q;
    res_status_d = res_status_q;
    res_cost_d   = res_cost_q;
    scan_start   = 1'b0;
    scan_key     = dest_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wentry   = '{dest: dest_q, via: via_q, cost: cost_q};
    out_load     = 1'b0;

    unique case (state_q)
      rtru_pkg::ST_IDLE: begin
        if (in_accept) begin
          dest_d = dest_address_i;
          via_d  = (action_i == rtru_pkg::ACT_ADVERT) ? via_address_i : own_q;
          cost_d = entry_cost_i;
          last_d = last_in_advert_i;
          if (dest_address_i == own_q) begin
            res_status_d = rtru_pkg::STATUS_SELF;
            res_cost_d   = '0;
            state_d      = rtru_pkg::ST_RESULT;
          end else if ((action_i == rtru_pkg::ACT_ADVERT) && (via_address_i != own_q)) begin
            scan_start = 1'b1;
            scan_key   = via_address_i;
            state_d    = rtru_pkg::ST_VIA_SCAN;
          end else begin
            scan_start = 1'b1;
            scan_key   = dest_address_i;
            state_d    = rtru_pkg::ST_DEST_SCAN;
          end
        end
      end

      rtru_pkg::ST_VIA_SCAN: begin
        if (scan_res.done) begin
          if (!scan_res.found) begin
            res_status_d = rtru_pkg::STATUS_NOVIA;
            res_cost_d   = '0;
            state_d      = rtru_pkg::ST_RESULT;
          end else begin
            cost_d     = sum_sat;
            scan_start = 1'b1;
            scan_key   = dest_q;
            state_d    = rtru_pkg::ST_DEST_SCAN;
          end
        end
      end

      rtru_pkg::ST_DEST_SCAN: begin
        if (scan_res.done) begin
          res_cost_d = cost_q;
          state_d    = rtru_pkg::ST_RESULT;
          if (!scan_res.found) begin
            if (count_q >= CW'(TABLE_DEPTH)) begin
              res_status_d = rtru_pkg::STATUS_FULL;
            end else begin
              ram_we       = 1'b1;
              count_d      = count_q + 1'b1;
              res_status_d = rtru_pkg::STATUS_INSERTED;
            end
          end else if (cost_q < rd_entry.cost) begin
            ram_we       = 1'b1;
            ram_waddr    = hit_idx;
            res_status_d = rtru_pkg::STATUS_IMPROVED;
          end else begin
            res_status_d = rtru_pkg::STATUS_UNCHANGED;
          end
        end
      end

      rtru_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rtru_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rtru_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_cost_d   = out_cost_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_cost_d   = res_cost_q;
      out_count_d  = rtru_pkg::COUNT_OUT_W'(count_q);
      out_last_d   = last_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtru_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q       <= dest_d;
    via_q        <= via_d;
    cost_q       <= cost_d;
    last_q       <= last_d;
    res_status_q <= res_status_d;
    res_cost_q   <= res_cost_d;
    out_status_q <= out_status_d;
    out_cost_q   <= out_cost_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign path_cost_o   = out_cost_q;
  assign table_count_o = out_count_q;
  assign last_done_o   = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("table fill count above depth");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write during a search read");

  a_scan_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == rtru_pkg::ST_VIA_SCAN ||
                       state_q == rtru_pkg::ST_DEST_SCAN))
    else $error("search finished outside a search state");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

@@ src/rtru_ram.sv @@
module rtru_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rtru_scan.sv @@
module rtru_scan #(
  parameter int unsigned TABLE_DEPTH = rtru_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [rtru_pkg::ADDR_W-1:0]          key_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count_i,
  output logic                                 rd_en_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr_o,
  input  logic [rtru_pkg::ADDR_W-1:0]          rd_dest_i,
  output rtru_pkg::scan_res_t                  res_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]       hit_idx_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic                        busy_q, busy_d;
  logic                        pend_q, pend_d;
  logic [CW-1:0]               issue_q, issue_d;
  logic [AW-1:0]               pend_idx_q, pend_idx_d;
  logic [rtru_pkg::ADDR_W-1:0] key_q, key_d;

  // Step through the valid entries, one read in flight, stop on first match
  always_comb begin
    res_o      = '0;
    rd_en_o    = 1'b0;
    busy_d     = busy_q;
    pend_d     = pend_q;
    issue_d    = issue_q;
    pend_idx_d = pend_idx_q;
    key_d      = key_q;
    if (busy_q) begin
      if (pend_q && (rd_dest_i == key_q)) begin
        res_o.done  = 1'b1;
        res_o.found = 1'b1;
        busy_d      = 1'b0;
        pend_d      = 1'b0;
      end else if (issue_q < count_i) begin
        rd_en_o    = 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = issue_q[AW-1:0];
        issue_d    = issue_q + 1'b1;
      end else if (!pend_q) begin
        res_o.done = 1'b1;
        busy_d     = 1'b0;
      end else begin
        pend_d = 1'b0;
      end
    end
    // Launch a new search
    if (start_i) begin
      rd_en_o = 1'b0;
      busy_d  = 1'b1;
      pend_d  = 1'b0;
      issue_d = '0;
      key_d   = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    key_q      <= key_d;
  end

  assign rd_addr_o = issue_q[AW-1:0];
  assign hit_idx_o = pend_idx_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TABLE_DEPTH = rtru_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned ADDR_W      = rtru_pkg::ADDR_W;
  localparam int unsigned COST_W      = rtru_pkg::COST_W;
  localparam int unsigned COUNT_OUT_W = rtru_pkg::COUNT_OUT_W;
  localparam int unsigned STATUS_W    = rtru_pkg::STATUS_W;
  localparam int unsigned APB_AW      = rtru_pkg::APB_AW;
  localparam int unsigned APB_DW      = rtru_pkg::APB_DW;

  // Expected result of one request
  typedef struct packed {
    rtru_pkg::status_e      status;
    logic [COST_W-1:0]      cost;
    logic [COUNT_OUT_W-1:0] count;
    logic                   last;
  } route_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   action_i = rtru_pkg::ACT_NEIGHBOR;
  logic [ADDR_W-1:0]      dest_address_i = '0;
  logic [ADDR_W-1:0]      via_address_i = '0;
  logic [COST_W-1:0]      entry_cost_i = '0;
  logic                   last_in_advert_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [COST_W-1:0]      path_cost_o;
  logic [COUNT_OUT_W-1:0] table_count_o;
  logic                   last_done_o;

  // Shadow routing table and own address
  logic [ADDR_W-1:0] own_shadow = '0;
  logic [ADDR_W-1:0] tbl_dest [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_via  [TABLE_DEPTH];
  logic [COST_W-1:0] tbl_cost [TABLE_DEPTH];
  int unsigned       tbl_count = 0;

  route_result_t pending_results[$];
  int unsigned   error_count = 0;
  bit            tx_quiet = 1'b0;
  bit            result_taken = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   cycle_cnt = 0;

  route_table_relax_update #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .dest_address_i  (dest_address_i),
    .via_address_i   (via_address_i),
    .entry_cost_i    (entry_cost_i),
    .last_in_advert_i(last_in_advert_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .path_cost_o     (path_cost_o),
    .table_count_o   (table_count_o),
    .last_done_o     (last_done_o)
  );

  always #6 clk_i = ~clk_i;

  // Lowest table index holding this destination, -1 if none
  function automatic int find_dest(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_dest[i] == addr) return i;
    end
    return -1;
  endfunction

  // Insert a new destination or lower the cost of a known one
  function automatic rtru_pkg::status_e relax_entry(input logic [ADDR_W-1:0] dest,
                                                    input logic [ADDR_W-1:0] via,
                                                    input logic [COST_W-1:0] cost);
    int j;
    j = find_dest(dest);
    if (j < 0) begin
      if (tbl_count >= TABLE_DEPTH) return rtru_pkg::STATUS_FULL;
      tbl_dest[tbl_count] = dest;
      tbl_via[tbl_count]  = via;
      tbl_cost[tbl_count] = cost;
      tbl_count++;
      return rtru_pkg::STATUS_INSERTED;
    end
    if (cost < tbl_cost[j]) begin
      tbl_via[j]  = via;
      tbl_cost[j] = cost;
      return rtru_pkg::STATUS_IMPROVED;
    end
    return rtru_pkg::STATUS_UNCHANGED;
  endfunction

  // Work out the result of one request and advance the shadow table
  function automatic route_result_t predict_route(input logic              act,
                                                  input logic [ADDR_W-1:0] dest,
                                                  input logic [ADDR_W-1:0] via,
                                                  input logic [COST_W-1:0] ecost,
                                                  input logic              last);
    route_result_t     res;
    int                k;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] base;
    res.status = rtru_pkg::STATUS_SELF;
    res.cost   = '0;
    res.last   = last;
    base       = '0;
    k          = 0;
    if (dest == own_shadow) begin
      res.status = rtru_pkg::STATUS_SELF;
    end else if (act == rtru_pkg::ACT_NEIGHBOR) begin
      res.cost   = ecost;
      res.status = relax_entry(dest, own_shadow, ecost);
    end else begin
      if (via != own_shadow) begin
        k = find_dest(via);
        if (k >= 0) base = tbl_cost[k];
      end
      if (k < 0) begin
        res.status = rtru_pkg::STATUS_NOVIA;
      end else begin
        sum        = {1'b0, ecost} + {1'b0, base};
        res.cost   = sum[COST_W] ? rtru_pkg::COST_MAX : sum[COST_W-1:0];
        res.status = relax_entry(dest, via, res.cost);
      end
    end
    res.count = tbl_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  // Random known destination, or any address while the table is empty
  function automatic logic [ADDR_W-1:0] pick_known();
    if (tbl_count == 0) return ADDR_W'($urandom);
    return tbl_dest[$urandom_range(0, tbl_count - 1)];
  endfunction

  // Address that is neither this node nor in the table
  function automatic logic [ADDR_W-1:0] fresh_address();
    logic [ADDR_W-1:0] a;
    do begin
      a = ADDR_W'($urandom);
    end while (a == own_shadow || find_dest(a) >= 0);
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
    error_count++;
  endtask

  // Send one request after a random gap and record its expected result
  task automatic send_request(input logic              act,
                              input logic [ADDR_W-1:0] dest,
                              input logic [ADDR_W-1:0] via,
                              input logic [COST_W-1:0] cost,
                              input logic              last);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    dest_address_i   <= dest;
    via_address_i    <= via;
    entry_cost_i     <= cost;
    last_in_advert_i <= last;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_results.push_back(predict_route(act, dest, via, cost, last));
  endtask

  // Drop valid and hold until every pending result has arrived
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {rtru_pkg::REG_OWN_ADDR, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write own_address while idle and read it back
  task automatic set_own_address(input logic [ADDR_W-1:0] addr);
    logic [APB_DW-1:0] rd;
    wait_drain();
    apb_access(1'b1, {{(APB_DW-ADDR_W){1'b0}}, addr}, rd);
    own_shadow = addr;
    apb_access(1'b0, '0, rd);
    if (rd[ADDR_W-1:0] !== addr) report_mismatch("own_address readback", rd, 32'(addr));
  endtask

  task automatic test_self_and_novia();
    send_request(rtru_pkg::ACT_NEIGHBOR, 16'h0000, 16'h1111, 16'h0022, 1'b1);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0005, 16'h0007, 16'h0010, 1'b1);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0005, 16'hFFFF, 16'h0000, 1'b0);
  endtask

  task automatic test_insert_and_saturate();
    send_request(rtru_pkg::ACT_NEIGHBOR, 16'h0010, 16'hAAAA, 16'hFFFF, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0020, 16'h0010, 16'h0001, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0030, 16'h0000, 16'h0000, 1'b1);
    send_request(rtru_pkg::ACT_NEIGHBOR, 16'hFFFF, 16'h5555, 16'h0000, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h1234, 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_improve_and_unchanged();
    send_request(rtru_pkg::ACT_ADVERT,   16'h0020, 16'h0030, 16'h0005, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0020, 16'h0030, 16'h0005, 1'b0);
    send_request(rtru_pkg::ACT_NEIGHBOR, 16'h0010, 16'h0000, 16'h0010, 1'b0);
    send_request(rtru_pkg::ACT_NEIGHBOR, 16'h0010, 16'h0000, 16'h0100, 1'b1);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0020, 16'h0010, 16'h0000, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0030, 16'hFFFF, 16'h0000, 1'b1);
  endtask

  // Move this node onto an address that is already in the table
  task automatic test_own_address_change();
    set_own_address(16'h0030);
    send_request(rtru_pkg::ACT_NEIGHBOR, 16'h0030, 16'h0000, 16'h0001, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0020, 16'h0030, 16'h0001, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT,   16'h0030, 16'h0010, 16'h0001, 1'b1);
    set_own_address(16'h0000);
  endtask

  // Fill the table, then offer new destinations
  task automatic test_table_full();
    while (tbl_count < TABLE_DEPTH) begin
      send_request(rtru_pkg::ACT_NEIGHBOR, fresh_address(), ADDR_W'($urandom),
                   COST_W'($urandom_range(1, 1000)), 1'($urandom_range(0, 1)));
    end
    send_request(rtru_pkg::ACT_NEIGHBOR, fresh_address(), ADDR_W'($urandom), 16'h0042, 1'b0);
    send_request(rtru_pkg::ACT_ADVERT, fresh_address(), own_shadow, 16'hFFFF, 1'b1);
    send_request(rtru_pkg::ACT_ADVERT, fresh_address(), tbl_dest[0], 16'hFFFF, 1'b0);
  endtask

  // Random requests, mostly about known nodes
  task automatic test_random_updates(input int unsigned n);
    logic              act;
    logic              last;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] via;
    logic [COST_W-1:0] cost;
    int unsigned       r;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 199) == 0) wait_drain();
      act = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      dest = (r < 60) ? pick_known() : (r < 70) ? own_shadow : ADDR_W'($urandom);
      r = $urandom_range(0, 99);
      via = (r < 70) ? pick_known() : (r < 85) ? own_shadow : ADDR_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 50) cost = COST_W'($urandom_range(0, 255));
      else if (r < 75) cost = COST_W'($urandom);
      else cost = 16'hFF00 | COST_W'($urandom_range(0, 255));
      last = ($urandom_range(0, 7) == 0);
      send_request(act, dest, via, cost, last);
    end
    tx_quiet = 1'b0;
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    route_result_t want;
    cycle_cnt++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_taken = 1'b1;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(status_o), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (path_cost_o !== want.cost)
          report_mismatch("path_cost", 32'(path_cost_o), 32'(want.cost));
        if (table_count_o !== want.count)
          report_mismatch("table_count", 32'(table_count_o), 32'(want.count));
        if (last_done_o !== want.last)
          report_mismatch("last_done", 32'(last_done_o), 32'(want.last));
      end
    end
  end

  // Stall the result side for a random count after each result
  always @(negedge clk_i) begin
    if (result_taken) begin
      stall_left   = ((cycle_cnt / 400) % 4 == 1) ? 0 : $urandom_range(0, 3);
      result_taken = 1'b0;
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_own_address(16'h0000);
    test_self_and_novia();
    test_insert_and_saturate();
    test_improve_and_unchanged();
    test_own_address_change();
    set_own_address(ADDR_W'($urandom));
    test_random_updates(500);
    test_table_full();
    set_own_address(16'hFFFF);
    test_random_updates(450);
    set_own_address(tbl_dest[$urandom_range(0, tbl_count - 1)]);
    test_random_updates(450);
    set_own_address(16'h0000);
    test_random_updates(400);
    wait_drain();
    repeat (2 * TABLE_DEPTH + 16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("route_table_relax_update: match");
    end else begin
      $display("route_table_relax_update: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("route_table_relax_update: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
src/rtru_pkg.sv
src/rtru_ram.sv
src/rtru_scan.sv
src/route_table_relax_update.sv
verif/tb_top.sv
